FILE: rtl/gpg_pkg.sv
// shared types, constants and register indexes of the gradient pixel generator
package gpg_pkg;

  localparam int CANVAS_DIM_DEF  = 4096;
  localparam int T_FRAC_BITS_DEF = 16;

  localparam int PIX_W   = 12;
  localparam int COORD_W = 13;
  localparam int DIFF_W  = 14;
  localparam int PROD_W  = 28;
  localparam int LEN_W   = 28;
  localparam int COLOR_W = 32;

  localparam logic [2:0] REG_X0    = 3'd0;
  localparam logic [2:0] REG_Y0    = 3'd1;
  localparam logic [2:0] REG_X1    = 3'd2;
  localparam logic [2:0] REG_Y1    = 3'd3;
  localparam logic [2:0] REG_START = 3'd4;
  localparam logic [2:0] REG_END   = 3'd5;
  localparam logic [2:0] REG_MODE  = 3'd6;

  localparam logic [1:0] KIND_BLACK = 2'd0;
  localparam logic [1:0] KIND_END   = 2'd1;
  localparam logic [1:0] KIND_TFIX  = 2'd2;
  localparam logic [1:0] KIND_DIV   = 2'd3;

  typedef struct packed {
    logic       vld;
    logic [1:0] kind;
    logic       radial;
    logic       t_one;
  } gpg_ctl_t;

endpackage

FILE: rtl/gpg_front.sv
// offsets, products, sums and classification of each pixel beat
module gpg_front
  import gpg_pkg::*;
#(
  parameter int CANVAS_DIM = CANVAS_DIM_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic                      in_vld,
  input  logic [PIX_W-1:0]          pixel_x,
  input  logic [PIX_W-1:0]          pixel_y,
  input  logic [COORD_W-1:0]        x0,
  input  logic [COORD_W-1:0]        y0,
  input  logic signed [DIFF_W-1:0]  dx,
  input  logic signed [DIFF_W-1:0]  dy,
  input  logic [LEN_W-1:0]          len2,
  input  logic                      radial,
  output gpg_ctl_t                  ctl_o,
  output logic [LEN_W-1:0]          num_o
);

  logic                     vld_a_r, off_a_r;
  logic signed [DIFF_W-1:0] rx_a_r, ry_a_r;
  logic                     vld_b_r, off_b_r;
  logic signed [PROD_W-1:0] pxd_b_r, pyd_b_r, pxx_b_r, pyy_b_r;
  gpg_ctl_t                 ctl_r, ctl_nxt;
  logic [LEN_W-1:0]         num_r, num_nxt;
  logic signed [PROD_W:0]   proj;
  logic [LEN_W-1:0]         d2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_a_r <= 1'b0;
      vld_b_r <= 1'b0;
      ctl_r   <= '0;
    end else if (en) begin
      vld_a_r <= in_vld;
      vld_b_r <= vld_a_r;
      ctl_r   <= ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      off_a_r <= (32'(pixel_x) >= 32'(CANVAS_DIM)) || (32'(pixel_y) >= 32'(CANVAS_DIM));
      rx_a_r  <= $signed({2'b00, pixel_x}) - $signed({x0[COORD_W-1], x0});
      ry_a_r  <= $signed({2'b00, pixel_y}) - $signed({y0[COORD_W-1], y0});
      off_b_r <= off_a_r;
      pxd_b_r <= rx_a_r * dx;
      pyd_b_r <= ry_a_r * dy;
      pxx_b_r <= rx_a_r * rx_a_r;
      pyy_b_r <= ry_a_r * ry_a_r;
      num_r   <= num_nxt;
    end
  end

  always_comb begin
    proj    = (PROD_W+1)'(pxd_b_r) + (PROD_W+1)'(pyd_b_r);
    d2      = LEN_W'($unsigned(pxx_b_r)) + LEN_W'($unsigned(pyy_b_r));
    ctl_nxt = '0;
    ctl_nxt.vld    = vld_b_r;
    ctl_nxt.radial = radial;
    num_nxt = '0;
    if (off_b_r) begin
      ctl_nxt.kind = KIND_BLACK;
    end else if (len2 == '0) begin
      ctl_nxt.kind = KIND_END;
    end else if (radial) begin
      if (d2 >= len2) begin
        ctl_nxt.kind  = KIND_TFIX;
        ctl_nxt.t_one = 1'b1;
      end else begin
        ctl_nxt.kind = KIND_DIV;
        num_nxt      = d2;
      end
    end else begin
      if (proj <= 0) begin
        ctl_nxt.kind = KIND_TFIX;
      end else if (proj >= $signed({1'b0, len2})) begin
        ctl_nxt.kind  = KIND_TFIX;
        ctl_nxt.t_one = 1'b1;
      end else begin
        ctl_nxt.kind = KIND_DIV;
        num_nxt      = proj[LEN_W-1:0];
      end
    end
  end

  assign ctl_o = ctl_r;
  assign num_o = num_r;

endmodule

FILE: rtl/gpg_div_stage.sv
// one restoring division step per register stage
module gpg_div_stage
  import gpg_pkg::*;
#(
  parameter int QW = 2 * T_FRAC_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic [LEN_W-1:0] len2,
  input  gpg_ctl_t         ctl_i,
  input  logic [LEN_W-1:0] rem_i,
  input  logic [QW-1:0]    quo_i,
  output gpg_ctl_t         ctl_o,
  output logic [LEN_W-1:0] rem_o,
  output logic [QW-1:0]    quo_o
);

  gpg_ctl_t         ctl_r;
  logic [LEN_W-1:0] rem_r, rem_nxt;
  logic [QW-1:0]    quo_r, quo_nxt;
  logic [LEN_W:0]   rem2, diff;
  logic             ge;

  always_comb begin
    rem2    = {rem_i, 1'b0};
    diff    = rem2 - {1'b0, len2};
    ge      = rem2 >= {1'b0, len2};
    rem_nxt = ge ? diff[LEN_W-1:0] : rem2[LEN_W-1:0];
    quo_nxt = {quo_i[QW-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (en) begin
      ctl_r <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign ctl_o = ctl_r;
  assign rem_o = rem_r;
  assign quo_o = quo_r;

endmodule

FILE: rtl/gpg_sqrt_stage.sv
// one digit of the integer square root per register stage
module gpg_sqrt_stage
  import gpg_pkg::*;
#(
  parameter int F    = T_FRAC_BITS_DEF,
  parameter int STEP = 0
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  gpg_ctl_t        ctl_i,
  input  logic [2*F-1:0]  quo_i,
  input  logic [F-1:0]    root_i,
  input  logic [F+2:0]    rem_i,
  output gpg_ctl_t        ctl_o,
  output logic [2*F-1:0]  quo_o,
  output logic [F-1:0]    root_o,
  output logic [F+2:0]    rem_o
);

  gpg_ctl_t       ctl_r;
  logic [2*F-1:0] quo_r;
  logic [F-1:0]   root_r, root_nxt;
  logic [F+2:0]   rem_r, rem_nxt, rem_sh, trial;
  logic           ge;

  always_comb begin
    rem_sh   = {rem_i[F:0], quo_i[2*STEP +: 2]};
    trial    = {1'b0, root_i, 2'b01};
    ge       = rem_sh >= trial;
    rem_nxt  = ge ? (rem_sh - trial) : rem_sh;
    root_nxt = {root_i[F-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (en) begin
      ctl_r <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      quo_r  <= quo_i;
      root_r <= root_nxt;
      rem_r  <= rem_nxt;
    end
  end

  assign ctl_o  = ctl_r;
  assign quo_o  = quo_r;
  assign root_o = root_r;
  assign rem_o  = rem_r;

endmodule

FILE: rtl/gpg_lerp.sv
// fraction select, per-channel blend products and rounded output register
module gpg_lerp
  import gpg_pkg::*;
#(
  parameter int F = T_FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  gpg_ctl_t           ctl_i,
  input  logic [2*F-1:0]     quo_i,
  input  logic [F-1:0]       root_i,
  input  logic [COLOR_W-1:0] start_color,
  input  logic [COLOR_W-1:0] end_color,
  output logic               vld_o,
  output logic [COLOR_W-1:0] color_o
);

  localparam logic [F:0] ONE  = (F+1)'(1) << F;
  localparam logic [F+8:0] HALF = (F+9)'(1) << (F-1);

  gpg_ctl_t           ctl1_r, ctl2_r;
  logic [F:0]         t1_r, t_nxt;
  logic [F+8:0]       ps_r [4];
  logic [F+8:0]       pe_r [4];
  logic               vld_r;
  logic [COLOR_W-1:0] color_r, color_nxt;
  logic [F+8:0]       sum [4];

  always_comb begin
    t_nxt = '0;
    case (ctl_i.kind)
      KIND_TFIX: t_nxt = ctl_i.t_one ? ONE : '0;
      KIND_DIV:  t_nxt = ctl_i.radial ? {1'b0, root_i} : {1'b0, quo_i[2*F-1:F]};
      default:   t_nxt = '0;
    endcase
  end

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      sum[c] = ps_r[c] + pe_r[c] + HALF;
    end
    color_nxt = '0;
    case (ctl2_r.kind)
      KIND_BLACK: color_nxt = '0;
      KIND_END:   color_nxt = end_color;
      default: begin
        for (int c = 0; c < 4; c++) begin
          color_nxt[8*c +: 8] = sum[c][F +: 8];
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r <= '0;
      ctl2_r <= '0;
      vld_r  <= 1'b0;
    end else if (en) begin
      ctl1_r <= ctl_i;
      ctl2_r <= ctl1_r;
      vld_r  <= ctl2_r.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t1_r <= t_nxt;
      for (int c = 0; c < 4; c++) begin
        ps_r[c] <= (F+9)'(start_color[8*c +: 8]) * (F+9)'(ONE - t1_r);
        pe_r[c] <= (F+9)'(end_color[8*c +: 8]) * (F+9)'(t1_r);
      end
      color_r <= color_nxt;
    end
  end

  assign vld_o   = vld_r;
  assign color_o = color_r;

endmodule

FILE: rtl/gradient_pixel_generator.sv
// top level of the gradient pixel generator
// Takes one pixel coordinate beat per clock and returns its ARGB color. The whole
// pipeline advances together whenever the output register is empty or taken, so
// throughput is one pixel per cycle. The pipeline holds one long-division step and one
// square-root digit per stage.
module gradient_pixel_generator
  import gpg_pkg::*;
#(
  parameter int CANVAS_DIM  = CANVAS_DIM_DEF,
  parameter int T_FRAC_BITS = T_FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // pixel_x, pixel_y
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // pixel_color
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [31:0] cfg_wdata
);

  localparam int F  = T_FRAC_BITS;
  localparam int QW = 2 * F;

  logic [COORD_W-1:0]       x0_r, y0_r, x1_r, y1_r;
  logic [COLOR_W-1:0]       start_r, end_r;
  logic                     radial_r;
  logic signed [DIFF_W-1:0] dx_r, dy_r;
  logic [LEN_W-1:0]         len2_r;
  logic                     en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x0_r     <= '0;
      y0_r     <= '0;
      x1_r     <= '0;
      y1_r     <= '0;
      start_r  <= '0;
      end_r    <= '0;
      radial_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_X0:    x0_r     <= cfg_wdata[COORD_W-1:0];
        REG_Y0:    y0_r     <= cfg_wdata[COORD_W-1:0];
        REG_X1:    x1_r     <= cfg_wdata[COORD_W-1:0];
        REG_Y1:    y1_r     <= cfg_wdata[COORD_W-1:0];
        REG_START: start_r  <= cfg_wdata;
        REG_END:   end_r    <= cfg_wdata;
        REG_MODE:  radial_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    dx_r   <= $signed({x1_r[COORD_W-1], x1_r}) - $signed({x0_r[COORD_W-1], x0_r});
    dy_r   <= $signed({y1_r[COORD_W-1], y1_r}) - $signed({y0_r[COORD_W-1], y0_r});
    len2_r <= LEN_W'($unsigned(PROD_W'(dx_r * dx_r))) + LEN_W'($unsigned(PROD_W'(dy_r * dy_r)));
  end

  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  gpg_ctl_t         dctl [QW+1];
  logic [LEN_W-1:0] drem [QW+1];
  logic [QW-1:0]    dquo [QW+1];

  gpg_front #(.CANVAS_DIM(CANVAS_DIM)) u_front (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_vld(in_tvalid),
    .pixel_x(in_tdata[11:0]), .pixel_y(in_tdata[23:12]),
    .x0(x0_r), .y0(y0_r), .dx(dx_r), .dy(dy_r), .len2(len2_r),
    .radial(radial_r),
    .ctl_o(dctl[0]), .num_o(drem[0])
  );
  assign dquo[0] = '0;

  for (genvar k = 0; k < QW; k++) begin : g_div
    gpg_div_stage #(.QW(QW)) u_div (
      .clk(clk), .rst_n(rst_n), .en(en), .len2(len2_r),
      .ctl_i(dctl[k]), .rem_i(drem[k]), .quo_i(dquo[k]),
      .ctl_o(dctl[k+1]), .rem_o(drem[k+1]), .quo_o(dquo[k+1])
    );
  end

  gpg_ctl_t     sctl  [F+1];
  logic [QW-1:0] squo [F+1];
  logic [F-1:0] sroot [F+1];
  logic [F+2:0] srem  [F+1];

  assign sctl[0]  = dctl[QW];
  assign squo[0]  = dquo[QW];
  assign sroot[0] = '0;
  assign srem[0]  = '0;

  for (genvar k = 0; k < F; k++) begin : g_sqrt
    gpg_sqrt_stage #(.F(F), .STEP(F-1-k)) u_sqrt (
      .clk(clk), .rst_n(rst_n), .en(en),
      .ctl_i(sctl[k]), .quo_i(squo[k]), .root_i(sroot[k]), .rem_i(srem[k]),
      .ctl_o(sctl[k+1]), .quo_o(squo[k+1]), .root_o(sroot[k+1]), .rem_o(srem[k+1])
    );
  end

  gpg_lerp #(.F(F)) u_lerp (
    .clk(clk), .rst_n(rst_n), .en(en),
    .ctl_i(sctl[F]), .quo_i(squo[F]), .root_i(sroot[F]),
    .start_color(start_r), .end_color(end_r),
    .vld_o(out_tvalid), .color_o(out_tdata)
  );

endmodule

FILE: rtl/gpg_checker.sv
// port-level assertions of the gradient pixel generator and their bind
module gpg_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

  a_ready_rule: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready == (!out_tvalid || out_tready))
    else $error("input ready does not follow output side");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled output beat changed");

endmodule

bind gradient_pixel_generator gpg_checker u_gpg_checker (
  .clk(clk), .rst_n(rst_n), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
);
